FILE: rtl/bf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_pkg: shared types and constants of the blowfish cipher core
// Command codes, table sizes, the reset pi words of the P array and the
// request struct that drives the S-box store.
// ----------------------------------------------------------------------------
package bf_pkg;

  // number of feistel rounds, 2 to 16
  localparam int ROUNDS    = 16;
  localparam int RND_W     = (ROUNDS > 2) ? $clog2(ROUNDS) : 1;

  localparam int WORD_W    = 32;
  localparam int P_DEPTH   = 18;
  localparam int P_IDX_W   = 5;
  localparam int IDX_W     = 10;
  localparam int S_BOXES   = 4;
  localparam int S_ENTRIES = 256;
  localparam int S_ADDR_W  = 8;
  localparam int S_SEL_W   = 2;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [P_IDX_W-1:0]  p_idx_t;
  typedef logic [RND_W-1:0]    rnd_t;
  typedef logic [S_ADDR_W-1:0] s_addr_t;
  typedef logic [S_SEL_W-1:0]  s_sel_t;

  typedef enum logic [1:0] {
    CMD_LOAD_P  = 2'd0,
    CMD_LOAD_S  = 2'd1,
    CMD_ENCRYPT = 2'd2,
    CMD_DECRYPT = 2'd3
  } cmd_t;

  // reset contents of the P array
  localparam word_t PI_WORDS [P_DEPTH] = '{
    32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344,
    32'ha4093822, 32'h299f31d0, 32'h082efa98, 32'hec4e6c89,
    32'h452821e6, 32'h38d01377, 32'hbe5466cf, 32'h34e90c6c,
    32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5, 32'hb5470917,
    32'h9216d5d9, 32'h8979fb1b
  };

  // request from the sequencer to the S-box store
  typedef struct packed {
    logic    wr_en;   // write this cycle
    logic    wr_all;  // write every box at wr_addr (clearing pass)
    s_sel_t  wr_box;  // box for a single write
    s_addr_t wr_addr;
    word_t   wr_data;
    word_t   lookup;  // word whose bytes address the four boxes
  } sbox_req_t;

endpackage

FILE: rtl/bf_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_ifs: channel interfaces of the blowfish cipher core
// Command items in, result blocks out, both with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bf_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [bf_pkg::IDX_W-1:0]      table_index;
  logic [bf_pkg::WORD_W-1:0]     table_word;
  logic [bf_pkg::WORD_W-1:0]     left_half;
  logic [bf_pkg::WORD_W-1:0]     right_half;

  modport source (output valid, command, table_index, table_word, left_half, right_half,
                  input ready);
  modport sink   (input valid, command, table_index, table_word, left_half, right_half,
                  output ready);
endinterface

interface bf_blk_if;
  logic                      valid;
  logic                      ready;
  logic [bf_pkg::WORD_W-1:0] left_result;
  logic [bf_pkg::WORD_W-1:0] right_result;

  modport source (output valid, left_result, right_result, input ready);
  modport sink   (input valid, left_result, right_result, output ready);
endinterface

FILE: rtl/bf_sbox_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_sbox_ram: one 256 x 32 S-box bank
// Single port synchronous ram, read first, with a registered read.
// ----------------------------------------------------------------------------
module bf_sbox_ram (
  input  logic            clk,
  input  logic            we,
  input  bf_pkg::s_addr_t addr,
  input  bf_pkg::word_t   wdata,
  output bf_pkg::word_t   rdata
);

  bf_pkg::word_t mem [bf_pkg::S_ENTRIES];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/bf_sbox_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_sbox_store: the four S-box banks and the round function
// Routes writes and lookups to the banks and combines the four read words
// into F = ((S0 + S1) ^ S2) + S3 in the cycle after the lookup.
// ----------------------------------------------------------------------------
module bf_sbox_store (
  input  logic              clk,
  input  bf_pkg::sbox_req_t req,
  output bf_pkg::word_t     f_value
);

  bf_pkg::word_t rd [bf_pkg::S_BOXES];

  for (genvar b = 0; b < bf_pkg::S_BOXES; b++) begin : g_bank
    logic            we;
    bf_pkg::s_addr_t addr;

    // box 0 takes the most significant byte
    assign we   = req.wr_en && (req.wr_all || (req.wr_box == bf_pkg::s_sel_t'(b)));
    assign addr = req.wr_en ? req.wr_addr
                            : req.lookup[bf_pkg::S_ADDR_W*(bf_pkg::S_BOXES-1-b) +:
                                         bf_pkg::S_ADDR_W];

    bf_sbox_ram u_ram (
      .clk   (clk),
      .we    (we),
      .addr  (addr),
      .wdata (req.wr_data),
      .rdata (rd[b])
    );
  end

  // round function from the registered bank outputs
  assign f_value = ((rd[0] + rd[1]) ^ rd[2]) + rd[3];

endmodule

FILE: rtl/blowfish_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blowfish_block_cipher: blowfish feistel core with loadable subkeys
// Sequencer, P array and output register around the S-box store.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per handshake: load P word, load S-box word
//   (index box*256+entry), encrypt or decrypt a block of two 32-bit halves.
//   blk returns one block for each encrypt or decrypt item, none for loads.
//   Loads leave ready high, so loads stream back to back.
//   A cipher item runs each round through ST_RND_A (address the four S-box
//   banks from L ^ P[k]) and ST_RND_B (fold the read words into R), then
//   ST_DONE for the output whitening: the result becomes valid and ready
//   returns in the same cycle, and ready stays low for the whole pass, so
//   the core takes no new item before a cipher item is through.
//   The registered S-box bank read is why each round needs both states.
//   Reset: P takes the pi constants at once; the S-boxes are cleared by a
//   pass over all 256 rows, all four banks one row a cycle, with ready low.
//   Stall: the result sits in an output register; loads are still accepted
//   while it waits, and a finished cipher item waits for the register.
// ----------------------------------------------------------------------------
module blowfish_block_cipher (
  input  logic     clk,
  input  logic     rst,
  bf_cmd_if.sink   cmd,
  bf_blk_if.source blk
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RND_A = 5'b00100,
    ST_RND_B = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t            state, state_next;
  bf_pkg::word_t     p_keys [bf_pkg::P_DEPTH];
  bf_pkg::word_t     l_half, r_half;
  bf_pkg::word_t     out_l, out_r;
  logic              out_valid;
  logic              reverse;
  bf_pkg::rnd_t      rnd;
  bf_pkg::s_addr_t   clr_cnt;
  bf_pkg::p_idx_t    key_idx;
  bf_pkg::word_t     l_keyed;
  bf_pkg::word_t     f_value;
  bf_pkg::sbox_req_t sreq;
  logic              accept;
  logic              last_rnd;
  logic              out_free;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign last_rnd  = (rnd == bf_pkg::rnd_t'(bf_pkg::ROUNDS - 1));
  assign out_free  = !out_valid || blk.ready;

  // round key index, forward or reversed
  assign key_idx = reverse ? bf_pkg::p_idx_t'(bf_pkg::ROUNDS + 1) - bf_pkg::p_idx_t'(rnd)
                           : bf_pkg::p_idx_t'(rnd);
  assign l_keyed = l_half ^ p_keys[key_idx];

  // S-box store requests
  always_comb begin
    sreq         = '0;
    sreq.lookup  = l_keyed;
    sreq.wr_addr = cmd.table_index[bf_pkg::S_ADDR_W-1:0];
    sreq.wr_box  = cmd.table_index[bf_pkg::IDX_W-1:bf_pkg::S_ADDR_W];
    sreq.wr_data = cmd.table_word;
    if (state == ST_CLEAR) begin
      sreq.wr_en   = 1'b1;
      sreq.wr_all  = 1'b1;
      sreq.wr_addr = clr_cnt;
      sreq.wr_data = '0;
    end else if (accept && (cmd.command == bf_pkg::CMD_LOAD_S)) begin
      sreq.wr_en = 1'b1;
    end
  end

  bf_sbox_store u_sbox (
    .clk     (clk),
    .req     (sreq),
    .f_value (f_value)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept && cmd.command[1]) state_next = ST_RND_A;
      end
      ST_RND_A: state_next = ST_RND_B;
      ST_RND_B: state_next = last_rnd ? ST_DONE : ST_RND_A;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_IDLE) begin
        rnd <= '0;
      end else if (state == ST_RND_B) begin
        rnd <= rnd + 1'b1;
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (blk.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // P array: pi constants at reset, loads in range only
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bf_pkg::P_DEPTH; i++) begin
        p_keys[i] <= bf_pkg::PI_WORDS[i];
      end
    end else if (accept && (cmd.command == bf_pkg::CMD_LOAD_P) &&
                 (cmd.table_index < bf_pkg::IDX_W'(bf_pkg::P_DEPTH))) begin
      p_keys[cmd.table_index[bf_pkg::P_IDX_W-1:0]] <= cmd.table_word;
    end
  end

  // block halves through the rounds
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && accept) begin
      l_half  <= cmd.left_half;
      r_half  <= cmd.right_half;
      reverse <= (cmd.command == bf_pkg::CMD_DECRYPT);
    end else if (state == ST_RND_A) begin
      l_half <= l_keyed;
    end else if (state == ST_RND_B) begin
      l_half <= r_half ^ f_value;
      r_half <= l_half;
    end
  end

  // undo the last swap and whiten into the output register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      if (reverse) begin
        out_l <= r_half ^ p_keys[0];
        out_r <= l_half ^ p_keys[1];
      end else begin
        out_l <= r_half ^ p_keys[bf_pkg::ROUNDS + 1];
        out_r <= l_half ^ p_keys[bf_pkg::ROUNDS];
      end
    end
  end

  assign blk.valid        = out_valid;
  assign blk.left_result  = out_l;
  assign blk.right_result = out_r;

endmodule

FILE: rtl/bf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_checker: port level checks of the blowfish cipher core
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module bf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_command,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bf_pkg::WORD_W-1:0] out_left,
  input logic [bf_pkg::WORD_W-1:0] out_right
);

  logic in_acc;
  logic cipher_acc;
  logic load_acc;

  assign in_acc     = in_valid && in_ready;
  assign cipher_acc = in_acc && ((in_command == bf_pkg::CMD_ENCRYPT) ||
                                 (in_command == bf_pkg::CMD_DECRYPT));
  assign load_acc   = in_acc && ((in_command == bf_pkg::CMD_LOAD_P) ||
                                 (in_command == bf_pkg::CMD_LOAD_S));

  // reset starts the clearing pass with ready low
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("ready high right after reset");

  // a cipher item holds off the next item
  a_busy_after_cipher: assert property (@(posedge clk) disable iff (rst)
    cipher_acc |=> !in_ready)
    else $error("item accepted during a cipher pass");

  // a load never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (load_acc && !out_valid) |=> !out_valid)
    else $error("result after a load item");

  // stalled result stays valid and stable
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_left) && $stable(out_right)))
    else $error("result changed while stalled");

endmodule

bind blowfish_block_cipher bf_checker u_bf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cmd.valid),
  .in_ready   (cmd.ready),
  .in_command (cmd.command),
  .out_valid  (blk.valid),
  .out_ready  (blk.ready),
  .out_left   (blk.left_result),
  .out_right  (blk.right_result)
);

FILE: tb/sv/bf_cipher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_cipher_checker: result predictor and comparator for the blowfish core
// Watches the command and result channels. It keeps its own copy of the
// P array and the S-boxes, applies every accepted load to them, and works
// out the block for every accepted encrypt or decrypt item. Each returned
// block is compared field by field against the oldest expected block.
// ----------------------------------------------------------------------------
module bf_cipher_checker
  import bf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bf_cmd_if    cmd,
  bf_blk_if    blk,
  output int   errors,
  output int   blocks_due,
  output int   blocks_checked
);

  typedef struct packed {
    word_t left;
    word_t right;
  } block_t;

  // round count from the package, clamped here to 2..16
  localparam int N_RND = (ROUNDS > 16) ? 16 : ((ROUNDS < 2) ? 2 : ROUNDS);

  word_t  p_keys   [P_DEPTH];
  word_t  sbox_mem [S_BOXES*S_ENTRIES];
  block_t expected_blocks [$];
  int     err_cnt   = 0;
  int     n_checked = 0;

  // round function: one byte of x addresses each box, msb byte to box 0
  function automatic word_t round_mix(word_t x);
    word_t a, b, c, d;
    a = sbox_mem[x[31:24]];
    b = sbox_mem[S_ENTRIES + x[23:16]];
    c = sbox_mem[2*S_ENTRIES + x[15:8]];
    d = sbox_mem[3*S_ENTRIES + x[7:0]];
    return ((a + b) ^ c) + d;
  endfunction

  // full feistel network, P words taken backwards for decryption
  function automatic block_t feistel_pass(word_t l, word_t r, logic inverse);
    word_t  t;
    int     k;
    block_t res;
    for (int i = 0; i < N_RND; i++) begin
      k = inverse ? (N_RND + 1 - i) : i;
      l = l ^ p_keys[k];
      r = r ^ round_mix(l);
      t = l;
      l = r;
      r = t;
    end
    t = l;
    l = r;
    r = t;
    if (inverse) begin
      r = r ^ p_keys[1];
      l = l ^ p_keys[0];
    end else begin
      r = r ^ p_keys[N_RND];
      l = l ^ p_keys[N_RND + 1];
    end
    res.left  = l;
    res.right = r;
    return res;
  endfunction

  always @(posedge clk) begin
    block_t want;
    if (rst) begin
      for (int i = 0; i < P_DEPTH; i++) p_keys[i] = PI_WORDS[i];
      foreach (sbox_mem[i]) sbox_mem[i] = '0;
      expected_blocks.delete();
    end else begin
      // result side first: a block leaving now was predicted earlier
      if (blk.valid && blk.ready) begin
        if (expected_blocks.size() == 0) begin
          err_cnt++;
          $error("unexpected block: left_result %h right_result %h",
                 blk.left_result, blk.right_result);
        end else begin
          want = expected_blocks.pop_front();
          if (blk.left_result !== want.left) begin
            err_cnt++;
            $error("left_result mismatch: expected %h, got %h", want.left, blk.left_result);
          end
          if (blk.right_result !== want.right) begin
            err_cnt++;
            $error("right_result mismatch: expected %h, got %h", want.right, blk.right_result);
          end
          n_checked++;
        end
      end
      // command side: update tables or queue the predicted block
      if (cmd.valid && cmd.ready) begin
        case (cmd_t'(cmd.command))
          CMD_LOAD_P: begin
            // P index out of range is dropped
            if (cmd.table_index < P_DEPTH) p_keys[cmd.table_index] = cmd.table_word;
          end
          CMD_LOAD_S: begin
            sbox_mem[cmd.table_index] = cmd.table_word;
          end
          CMD_ENCRYPT: begin
            expected_blocks.push_back(feistel_pass(cmd.left_half, cmd.right_half, 1'b0));
          end
          CMD_DECRYPT: begin
            expected_blocks.push_back(feistel_pass(cmd.left_half, cmd.right_half, 1'b1));
          end
          default: begin
          end
        endcase
      end
    end
    errors         <= err_cnt;
    blocks_due     <= expected_blocks.size();
    blocks_checked <= n_checked;
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the blowfish cipher core
// Drives directed loads and cipher items at the table and field extremes,
// then a long random mix of P loads, S-box loads, encrypts and decrypts
// with random gaps and result stalls, including one long result stall that
// backs the core up. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import bf_pkg::*;

  logic clk;
  logic rst;
  logic calm;
  int   fail_count;
  int   blocks_due;
  int   blocks_checked;
  int   loads_sent   = 0;
  int   ciphers_sent = 0;
  int   blocks_taken = 0;

  bf_cmd_if cmd_ch ();
  bf_blk_if blk_ch ();

  blowfish_block_cipher dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .blk (blk_ch)
  );

  bf_cipher_checker chk (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .blk            (blk_ch),
    .errors         (fail_count),
    .blocks_due     (blocks_due),
    .blocks_checked (blocks_checked)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // data words biased toward zero, all ones and single bits
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // offer one item after a random gap, return at its acceptance edge
  task automatic send_item(input cmd_t op, input logic [IDX_W-1:0] idx, input word_t w,
                           input word_t l, input word_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= op;
    cmd_ch.table_index <= idx;
    cmd_ch.table_word  <= w;
    cmd_ch.left_half   <= l;
    cmd_ch.right_half  <= r;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (op == CMD_LOAD_P || op == CMD_LOAD_S) loads_sent++;
    else ciphers_sent++;
  endtask

  // result side: random stalls, one long hold-off to back the core up
  initial begin : receiver
    int stall;
    blk_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (blocks_taken == 30) stall = 400;
      if (stall > 0) begin
        blk_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      blk_ch.ready <= 1'b1;
      @(posedge clk);
      while (!blk_ch.valid) @(posedge clk);
      blocks_taken++;
    end
  end

  // stimulus
  initial begin : stimulus
    int               pick;
    logic [IDX_W-1:0] idx;
    calm                = 1'b0;
    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.command     <= CMD_LOAD_P;
    cmd_ch.table_index <= '0;
    cmd_ch.table_word  <= '0;
    cmd_ch.left_half   <= '0;
    cmd_ch.right_half  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset tables: pi P words, cleared S-boxes; unused fields set
    send_item(CMD_ENCRYPT, '0, '0, '0, '0);
    send_item(CMD_DECRYPT, '1, '1, '1, '1);
    send_item(CMD_ENCRYPT, 10'h155, 32'h5a5a5a5a, 32'h80000000, 32'h00000001);
    // first and last entry of every box, halves ignored on loads
    send_item(CMD_LOAD_S, 10'd0, '1, '1, '1);
    send_item(CMD_LOAD_S, 10'd255, 32'h01234567, '0, '0);
    send_item(CMD_LOAD_S, 10'd256, 32'h89abcdef, '1, '0);
    send_item(CMD_LOAD_S, 10'd511, 32'hfedcba98, '0, '1);
    send_item(CMD_LOAD_S, 10'd512, 32'h76543210, '0, '0);
    send_item(CMD_LOAD_S, 10'd767, 32'h0f0f0f0f, '0, '0);
    send_item(CMD_LOAD_S, 10'd768, 32'hf0f0f0f0, '0, '0);
    send_item(CMD_LOAD_S, 10'd1023, '1, '0, '0);
    send_item(CMD_ENCRYPT, '0, '0, '1, '1);
    // P words at both ends, then out-of-range P indexes
    send_item(CMD_LOAD_P, 10'd0, '0, '1, '1);
    send_item(CMD_LOAD_P, 10'd17, '1, '0, '0);
    send_item(CMD_LOAD_P, 10'd18, 32'hdeadbeef, '0, '0);
    send_item(CMD_LOAD_P, 10'd1023, 32'hcafef00d, '0, '0);
    send_item(CMD_ENCRYPT, '0, '0, 32'h01234567, 32'h89abcdef);
    send_item(CMD_DECRYPT, '0, '0, 32'h01234567, 32'h89abcdef);
    send_item(CMD_ENCRYPT, '1, '1, '0, '1);
    send_item(CMD_DECRYPT, '0, '0, '1, '0);

    // random mix; every third chunk runs without gaps or stalls
    for (int n = 0; n < 1400; n++) begin
      if (n % 200 == 0) calm = ((n / 200) % 3 == 1);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_item(CMD_LOAD_S, IDX_W'($urandom_range(0, 1023)), rand_word(), $urandom,
                  $urandom);
      end else if (pick < 40) begin
        idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(18, 1023))
                                          : IDX_W'($urandom_range(0, 17));
        send_item(CMD_LOAD_P, idx, rand_word(), $urandom, $urandom);
      end else begin
        send_item((pick < 70) ? CMD_ENCRYPT : CMD_DECRYPT, IDX_W'($urandom_range(0, 1023)),
                  $urandom, rand_word(), rand_word());
      end
    end
    cmd_ch.valid <= 1'b0;
    calm = 1'b0;

    // drain, then let the core settle
    @(posedge clk);
    while (blocks_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d table loads and %0d cipher items, %0d blocks compared",
             loads_sent, ciphers_sent, blocks_checked);
    $display("with random gaps and stalls, gap-free stretches and one long result stall");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
